[hw/rtl/sas_pkg.sv]
// Shared types and constants for the sorted address set.
// No dependencies; every other file of the block imports this package.
package sas_pkg;

    // Operation codes carried on s_tuser.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Result item layout on m_tdata, lowest bit first.
    localparam int RES_FOUND_BIT  = 0;
    localparam int RES_STORED_BIT = 1;
    localparam int RES_FULL_BIT   = 2;
    localparam int RES_COUNT_LSB  = 3;
    localparam int RES_COUNT_W    = 9;
    localparam int RES_TDATA_W    = 16;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic compare;  // compare each held entry with the incoming key
        logic insert;   // open a gap at the boundary cell and store the key
    } sas_cell_ctrl_t;

endpackage

[hw/rtl/sorted_address_set.sv]
// Top level of the sorted address set: handshake, sequencer, count and
// result register around the cell chain. Depends on sas_pkg and sas_chain.
//
// The block keeps up to CAPACITY distinct addresses in ascending order in a
// chain of cells, one entry per cell. Each item is an insert (s_tuser = 0)
// or a membership query (s_tuser = 1) for the address on s_tdata, and
// yields exactly one result item. In the cycle an item is accepted every
// cell compares its entry with the key. Then, once the result register is
// free (ST_UPDATE or ST_HOLD), the match flags are combined, the result is
// registered and, for a new address with room left, cells from the insert
// point up shift one place toward the top and the key lands in the gap.
// s_tready stays low until then, so no new item is taken before the last
// is done. An insert into a full table is refused with full_res set. Reset
// clears every cell's valid flag at once, so no clearing pass is needed.
module sorted_address_set
    import sas_pkg::*;
#(
    parameter int CAPACITY     = 256,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // s_tdata: address, zero-filled to whole bytes
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((ADDRESS_BITS+7)/8)*8-1:0]       s_tdata,
    // s_tuser: operation (0 = insert, 1 = query)
    input  logic                                    s_tuser,
    // m_tdata: found [0], stored [1], full_res [2], entry_count [11:3]
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [RES_TDATA_W-1:0]                  m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_HOLD   = 3'b100
    } sas_state_t;

    sas_state_t              state_reg;
    sas_state_t              state_next;
    logic [ADDRESS_BITS-1:0] key_reg;
    logic                    op_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    m_tvalid_reg;
    logic [RES_TDATA_W-1:0]  m_tdata_reg;
    logic [RES_TDATA_W-1:0]  m_tdata_next;

    logic                    accept;
    logic                    out_free;
    logic                    finish;
    logic                    found;
    logic                    is_full;
    logic                    do_store;
    logic                    do_refuse;
    logic [CNT_W+RES_COUNT_W-1:0] count_ext;
    sas_cell_ctrl_t          cell_ctrl;

    // Handshake and item bookkeeping.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg != ST_IDLE) && out_free;

    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign do_store  = finish && (op_reg == OP_INSERT) && !found && !is_full;
    assign do_refuse = (op_reg == OP_INSERT) && !found && is_full;

    assign cell_ctrl.compare = accept;
    assign cell_ctrl.insert  = do_store;

    sas_chain #(
        .CAPACITY     (CAPACITY),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cell_ctrl),
        .cmp_key (s_tdata[ADDRESS_BITS-1:0]),
        .ins_key (key_reg),
        .found   (found)
    );

    // Sequencer: the update step waits in ST_HOLD while the result register holds an untaken item.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = out_free ? ST_UPDATE : ST_HOLD;
                end
            end
            ST_UPDATE, ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Key and operation of the item in progress.
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg <= s_tdata[ADDRESS_BITS-1:0];
            op_reg  <= s_tuser;
        end
    end

    // Entry count.
    assign count_next = do_store ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result register.
    assign count_ext = {{RES_COUNT_W{1'b0}}, count_next};

    always_comb begin
        m_tdata_next                 = '0;
        m_tdata_next[RES_FOUND_BIT]  = found;
        m_tdata_next[RES_STORED_BIT] = do_store;
        m_tdata_next[RES_FULL_BIT]   = do_refuse;
        m_tdata_next[RES_COUNT_LSB +: RES_COUNT_W] = count_ext[RES_COUNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/sas_cell.sv]
// One slot of the sorted chain: holds one entry, its valid flag and the
// compare flags of the current item. Depends on sas_pkg.
module sas_cell
    import sas_pkg::*;
#(
    parameter int ADDRESS_BITS = 48
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sas_cell_ctrl_t          ctrl,
    input  logic [ADDRESS_BITS-1:0] cmp_key,
    input  logic [ADDRESS_BITS-1:0] ins_key,
    input  logic [ADDRESS_BITS-1:0] prev_entry,
    input  logic                    prev_valid,
    input  logic                    prev_lt,
    output logic [ADDRESS_BITS-1:0] entry,
    output logic                    valid,
    output logic                    lt,
    output logic                    eq
);

    logic [ADDRESS_BITS-1:0] entry_reg;
    logic                    valid_reg;
    logic                    lt_reg;
    logic                    eq_reg;

    // Compare flags: the lt flags form a thermometer over the chain, since
    // valid entries are ascending and sit in the lowest cells.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end else if (ctrl.compare) begin
            lt_reg <= valid_reg && (entry_reg < cmp_key);
            eq_reg <= valid_reg && (entry_reg == cmp_key);
        end
    end

    // Cells at or above the insert point take their lower neighbor's entry;
    // the first such cell takes the new key instead.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.insert && !lt_reg) begin
            if (prev_lt) begin
                valid_reg <= 1'b1;
            end else begin
                valid_reg <= prev_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.insert && !lt_reg) begin
            if (prev_lt) begin
                entry_reg <= ins_key;
            end else begin
                entry_reg <= prev_entry;
            end
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

[hw/rtl/sas_chain.sv]
// Row of sas_cell slots wired neighbor to neighbor, plus the OR of the
// match flags. Depends on sas_pkg and sas_cell.
module sas_chain
    import sas_pkg::*;
#(
    parameter int CAPACITY     = 256,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sas_cell_ctrl_t          ctrl,
    input  logic [ADDRESS_BITS-1:0] cmp_key,
    input  logic [ADDRESS_BITS-1:0] ins_key,
    output logic                    found
);

    logic [ADDRESS_BITS-1:0] entry_vec [CAPACITY];
    logic [CAPACITY-1:0]     valid_vec;
    logic [CAPACITY-1:0]     lt_vec;
    logic [CAPACITY-1:0]     eq_vec;

    // Cell 0 has no lower neighbor: it behaves as if that neighbor were
    // below the key, so it becomes the insert point when it is not below.
    sas_cell #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_cell0 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .cmp_key    (cmp_key),
        .ins_key    (ins_key),
        .prev_entry (ins_key),
        .prev_valid (1'b1),
        .prev_lt    (1'b1),
        .entry      (entry_vec[0]),
        .valid      (valid_vec[0]),
        .lt         (lt_vec[0]),
        .eq         (eq_vec[0])
    );

    // Remaining cells each see their lower neighbor.
    for (genvar i = 1; i < CAPACITY; i++) begin : g_cell
        sas_cell #(
            .ADDRESS_BITS(ADDRESS_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .cmp_key    (cmp_key),
            .ins_key    (ins_key),
            .prev_entry (entry_vec[i-1]),
            .prev_valid (valid_vec[i-1]),
            .prev_lt    (lt_vec[i-1]),
            .entry      (entry_vec[i]),
            .valid      (valid_vec[i]),
            .lt         (lt_vec[i]),
            .eq         (eq_vec[i])
        );
    end

    // At most one cell matches, since entries are unique.
    assign found = |eq_vec;

endmodule

[hw/rtl/sas_checker.sv]
// Port-level checks for sorted_address_set and the bind that attaches them.
// Depends on sas_pkg and sorted_address_set.
module sas_checker
    import sas_pkg::*;
#(
    parameter int CAPACITY     = 256,
    parameter int ADDRESS_BITS = 48
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [((ADDRESS_BITS+7)/8)*8-1:0] s_tdata,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [RES_TDATA_W-1:0]            m_tdata
);

    localparam logic [RES_COUNT_W-1:0] CAP_LOW = RES_COUNT_W'(CAPACITY);

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // Items are worked one at a time: no acceptance in back-to-back cycles.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // An address already held is never stored again or refused.
    a_found_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[RES_FOUND_BIT] &&
                       (m_tdata[RES_STORED_BIT] || m_tdata[RES_FULL_BIT])))
        else $error("found item also stored or refused");

    // A refused insert reports a full table.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[RES_FULL_BIT] |->
            m_tdata[RES_COUNT_LSB +: RES_COUNT_W] == CAP_LOW)
        else $error("refused insert with table not full");

endmodule

bind sorted_address_set sas_checker #(
    .CAPACITY     (CAPACITY),
    .ADDRESS_BITS (ADDRESS_BITS)
) u_sas_checker (.*);

[verif/address_set_checker.sv]
// Channel monitor and checker for the sorted address set.
// Keeps its own sorted copy of the held addresses and compares every result item.
// Depends on sas_pkg for the operation codes and the result layout.
module address_set_checker
    import sas_pkg::*;
#(
    parameter int CAPACITY     = 256,
    parameter int ADDRESS_BITS = 48,
    parameter int S_DATA_W     = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [RES_TDATA_W-1:0] m_tdata,
    output int                     mismatch_count,
    output int                     outstanding
);

    typedef struct packed {
        logic       found;
        logic       stored;
        logic       full_res;
        logic [8:0] entry_count;
    } set_outcome_t;

    // Ascending copy of the addresses the block should hold.
    logic [ADDRESS_BITS-1:0] mirror_entries[$];
    set_outcome_t            expected_outcomes[$];
    int                      fail_total = 0;
    int                      waiting_total = 0;

    assign mismatch_count = fail_total;
    assign outstanding    = waiting_total;

    // Applies one item to the mirror and returns the outcome it should report.
    function automatic set_outcome_t predict_set_outcome(logic op,
                                                         logic [ADDRESS_BITS-1:0] addr);
        set_outcome_t res;
        int pos;
        res = '0;
        pos = 0;
        while (pos < mirror_entries.size() && mirror_entries[pos] < addr)
            pos++;
        res.found = (pos < mirror_entries.size()) && (mirror_entries[pos] == addr);
        if (op == OP_INSERT && !res.found) begin
            if (mirror_entries.size() >= CAPACITY) begin
                res.full_res = 1'b1;
            end else begin
                mirror_entries.insert(pos, addr);
                res.stored = 1'b1;
            end
        end
        res.entry_count = 9'(mirror_entries.size());
        return res;
    endfunction

    function automatic int check_field(string name, logic [8:0] want, logic [8:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Results are checked before the item accepted at the same edge is predicted;
    // the block's registered result path keeps the two apart anyway.
    always @(posedge aclk) begin : monitor
        set_outcome_t seen;
        set_outcome_t want;
        int errs;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen.found       = m_tdata[RES_FOUND_BIT];
                seen.stored      = m_tdata[RES_STORED_BIT];
                seen.full_res    = m_tdata[RES_FULL_BIT];
                seen.entry_count = m_tdata[RES_COUNT_LSB +: RES_COUNT_W];
                if (expected_outcomes.size() == 0) begin
                    $error("result item with no item waiting for it: m_tdata = %h", m_tdata);
                    fail_total++;
                end else begin
                    want = expected_outcomes.pop_front();
                    errs = check_field("found", 9'(want.found), 9'(seen.found))
                         + check_field("stored", 9'(want.stored), 9'(seen.stored))
                         + check_field("full_res", 9'(want.full_res), 9'(seen.full_res))
                         + check_field("entry_count", want.entry_count, seen.entry_count);
                    fail_total += errs;
                end
            end
            if (s_tvalid && s_tready)
                expected_outcomes.push_back(
                    predict_set_outcome(s_tuser, s_tdata[ADDRESS_BITS-1:0]));
            waiting_total = expected_outcomes.size();
        end
    end

endmodule

[verif/testbench.sv]
// Top of the sorted address set testbench: clock, reset, stimulus and verdict.
// Instantiates sorted_address_set and address_set_checker; depends on sas_pkg.
module testbench
    import sas_pkg::*;
();

    localparam int CAPACITY     = 256;
    localparam int ADDR_W       = 48;
    localparam int S_DATA_W     = ((ADDR_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT   = 3000;
    localparam int GROWTH_ITEMS = 450;
    localparam int FILL_INSERTS = 260;
    localparam int FULL_ITEMS   = 260;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata  = '0;
    logic                   s_tuser  = OP_INSERT;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [RES_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int outstanding;
    int idle_cycles = 0;
    int ready_hold  = 0;
    int items_sent  = 0;
    bit no_gaps     = 1'b0;

    // Addresses offered for insertion so far, reused for hits and neighbors.
    logic [ADDR_W-1:0] offered_addrs[$];

    sorted_address_set #(
        .CAPACITY     (CAPACITY),
        .ADDRESS_BITS (ADDR_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    address_set_checker #(
        .CAPACITY     (CAPACITY),
        .ADDRESS_BITS (ADDR_W),
        .S_DATA_W     (S_DATA_W)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side back-pressure: short bursts and stalls, now and then a long one.
    always @(posedge aclk) begin : ready_gen
        int pick;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 7);
            end else if (pick < 88) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else if (pick < 96) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(20, 60);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        int pick;
        if (no_gaps)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [ADDR_W-1:0] fresh_address();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    // Mixes repeats of earlier addresses, their neighbors, the extremes and fresh values.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] addr;
        int pick;
        addr = fresh_address();
        pick = $urandom_range(0, 99);
        if (offered_addrs.size() > 0 && pick < 45) begin
            addr = offered_addrs[$urandom_range(0, offered_addrs.size() - 1)];
        end else if (offered_addrs.size() > 0 && pick < 60) begin
            addr = offered_addrs[$urandom_range(0, offered_addrs.size() - 1)];
            addr = $urandom_range(0, 1) ? addr + 1'b1 : addr - 1'b1;
        end else if (pick < 65) begin
            addr = ADDR_W'($urandom_range(0, 15));
        end else if (pick < 70) begin
            addr = '1 - ADDR_W'($urandom_range(0, 15));
        end
        return addr;
    endfunction

    // Presents one item and returns at the edge that accepts it.
    task automatic send_item(logic op, logic [ADDR_W-1:0] addr);
        int gap;
        if (items_sent % 64 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_DATA_W'(addr);
        @(negedge aclk);
        while (!s_tready)
            @(negedge aclk);
        @(posedge aclk);
        if (op == OP_INSERT)
            offered_addrs.push_back(addr);
        items_sent++;
    endtask

    initial begin : stimulus
        int fresh_done;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, extremes, duplicates, absent keys, shifts in the middle.
        send_item(OP_QUERY,  '0);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, '1);
        send_item(OP_INSERT, '0);
        send_item(OP_QUERY,  '0);
        send_item(OP_QUERY,  '1);
        send_item(OP_QUERY,  ADDR_W'(1));
        send_item(OP_INSERT, {(ADDR_W/2){2'b01}});
        send_item(OP_INSERT, {(ADDR_W/2){2'b10}});
        send_item(OP_INSERT, ADDR_W'(1));
        send_item(OP_INSERT, '1 - 1'b1);
        send_item(OP_INSERT, {1'b1, {(ADDR_W-1){1'b0}}});
        send_item(OP_QUERY,  {(ADDR_W/2){2'b10}});
        send_item(OP_INSERT, {(ADDR_W/2){2'b10}});
        send_item(OP_QUERY,  {(ADDR_W/2){2'b01}});
        send_item(OP_QUERY,  {1'b0, {(ADDR_W-1){1'b1}}});
        send_item(OP_INSERT, '1);

        // Growth: mostly lookups, with inserts filling the table slowly.
        repeat (GROWTH_ITEMS)
            send_item(($urandom_range(0, 99) < 35) ? OP_INSERT : OP_QUERY, pick_address());

        // Fill: fresh random inserts until the table is certainly full.
        fresh_done = 0;
        while (fresh_done < FILL_INSERTS) begin
            if ($urandom_range(0, 99) < 80) begin
                send_item(OP_INSERT, fresh_address());
                fresh_done++;
            end else begin
                send_item(OP_QUERY, pick_address());
            end
        end

        // Full table: refused inserts, duplicate inserts and lookups.
        repeat (FULL_ITEMS)
            send_item(($urandom_range(0, 99) < 60) ? OP_INSERT : OP_QUERY, pick_address());

        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sas_pkg.sv
hw/rtl/sas_cell.sv
hw/rtl/sas_chain.sv
hw/rtl/sorted_address_set.sv
hw/rtl/sas_checker.sv
verif/address_set_checker.sv
verif/testbench.sv
